FILE: hw/rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg: shared types and constants for the tick scheduler
// Job entry layout, event and command codes, controller/datapath structs,
// and the ordering function used during the pick scan.
// ----------------------------------------------------------------------------
package fss_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] EV_RUN  = 2'd0;
	localparam logic [1:0] EV_FIN  = 2'd1;
	localparam logic [1:0] EV_IDLE = 2'd2;
	localparam logic [1:0] EV_DONE = 2'd3;

	localparam logic POLICY_FCFS = 1'b0;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] arr;
		logic [15:0] rem;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       scan_start;
		logic       take;
		logic       mark_done;
		logic       set_all_fin;
		logic       emit;
		logic [1:0] kind;
		logic       last;
		logic       dec_rem;
		logic       time_inc;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic all_fin;
		logic cur_valid;
		logic cur_arrived;
		logic cur_rem_zero;
		logic scan_done;
		logic scan_found;
		logic out_free;
	} dp_stat_t;

	// true when candidate a must be served before b
	function automatic logic goes_first(input logic policy, input logic [31:0] now,
		input job_t a, input job_t b);
		logic [31:0] ka;
		logic [31:0] kb;
		logic        r;
		ka = ({16'd0, a.arr} > now) ? {16'd0, a.arr} : now;
		kb = ({16'd0, b.arr} > now) ? {16'd0, b.arr} : now;
		if (policy == POLICY_FCFS) begin
			if (a.arr != b.arr) r = (a.arr < b.arr);
			else                r = (a.id < b.id);
		end else begin
			if (ka != kb)             r = (ka < kb);
			else if (a.rem != b.rem)  r = (a.rem < b.rem);
			else                      r = (a.id < b.id);
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/fss_if.sv
// ----------------------------------------------------------------------------
// fss_if: valid/ready channels of the tick scheduler
// Command channel into the block and event channel out of it.
// ----------------------------------------------------------------------------
interface fss_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] job_id;
	logic [15:0] arrival_time;
	logic [15:0] burst_length;

	modport source (output valid, cmd, job_id, arrival_time, burst_length, input ready);
	modport sink   (input valid, cmd, job_id, arrival_time, burst_length, output ready);
endinterface

interface fss_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [15:0] event_job;
	logic [31:0] event_time;
	logic        last_of_tick;

	modport source (output valid, event_kind, event_job, event_time, last_of_tick,
		input ready);
	modport sink   (input valid, event_kind, event_job, event_time, last_of_tick,
		output ready);
endinterface

FILE: hw/rtl/fss_ram.sv
// ----------------------------------------------------------------------------
// fss_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fss_ram #(
	parameter  int WIDTH = 48,
	parameter  int DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/fss_ctrl.sv
// ----------------------------------------------------------------------------
// fss_ctrl: tick scheduler controller
// Sequences loads, pick scans, evaluation of the selected job and event output.
// ----------------------------------------------------------------------------
module fss_ctrl import fss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_cmd,
	output logic       in_ready,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_TICK  = 4'd1;
	localparam logic [3:0] S_SCAN  = 4'd2;
	localparam logic [3:0] S_EVAL  = 4'd3;
	localparam logic [3:0] S_EVAL2 = 4'd4;
	localparam logic [3:0] S_RUN   = 4'd5;
	localparam logic [3:0] S_IDLEV = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;
	localparam logic [3:0] S_FIN0  = 4'd8;
	localparam logic [3:0] S_FIN0D = 4'd9;
	localparam logic [3:0] S_FIN1  = 4'd10;

	logic [3:0] st_q, st_d;
	logic       second_q, second_d;

	always_comb begin
		cmd      = '0;
		st_d     = st_q;
		second_d = second_q;
		in_ready = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == CMD_LOAD) cmd.load = 1'b1;
					else                    st_d = S_TICK;
				end
			end
			S_TICK: begin
				if (stat.all_fin) begin
					st_d = S_DONE;
				end else if (!stat.cur_valid) begin
					cmd.scan_start = 1'b1;
					second_d       = 1'b0;
					st_d           = S_SCAN;
				end else begin
					st_d = S_EVAL;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					if (stat.scan_found) begin
						cmd.take = 1'b1;
						st_d     = second_q ? S_EVAL2 : S_EVAL;
					end else begin
						cmd.set_all_fin = 1'b1;
						st_d            = second_q ? S_FIN0D : S_DONE;
					end
				end
			end
			S_EVAL: begin
				if (stat.cur_arrived && !stat.cur_rem_zero) begin
					st_d = S_RUN;
				end else if (stat.cur_arrived) begin
					// retire the job, then pick its successor
					cmd.mark_done  = 1'b1;
					cmd.scan_start = 1'b1;
					second_d       = 1'b1;
					st_d           = S_SCAN;
				end else begin
					st_d = S_IDLEV;
				end
			end
			S_EVAL2: begin
				if (stat.cur_arrived && !stat.cur_rem_zero) st_d = S_FIN0;
				else                                        st_d = S_FIN1;
			end
			S_RUN: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = EV_RUN;
					cmd.last     = 1'b1;
					cmd.dec_rem  = 1'b1;
					cmd.time_inc = 1'b1;
					st_d         = S_IDLE;
				end
			end
			S_IDLEV: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = EV_IDLE;
					cmd.last     = 1'b1;
					cmd.time_inc = 1'b1;
					st_d         = S_IDLE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EV_DONE;
					cmd.last = 1'b1;
					st_d     = S_IDLE;
				end
			end
			S_FIN0: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EV_FIN;
					st_d     = S_RUN;
				end
			end
			S_FIN0D: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EV_FIN;
					st_d     = S_DONE;
				end
			end
			S_FIN1: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = EV_FIN;
					cmd.last     = 1'b1;
					cmd.time_inc = 1'b1;
					st_d         = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			second_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			second_q <= second_d;
		end
	end

endmodule

FILE: hw/rtl/fss_dp.sv
// ----------------------------------------------------------------------------
// fss_dp: tick scheduler datapath
// Job table RAM, done flags, selected job, pick scan unit, time and event register.
// ----------------------------------------------------------------------------
module fss_dp import fss_pkg::*; #(
	parameter int MAX_JOBS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic [15:0]      job_id,
	input  logic [15:0]      arrival_time,
	input  logic [15:0]      burst_length,
	input  ctrl_cmd_t        cmd,
	output dp_stat_t         stat,
	fss_out_if.source        ev
);

	localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CW = $clog2(MAX_JOBS + 1);

	logic                policy_q;
	logic [CW-1:0]       count_q;
	logic [MAX_JOBS-1:0] done_q;
	logic                all_fin_q;
	logic [31:0]         time_q;
	logic                cur_valid_q;
	logic [IW-1:0]       cur_idx_q;
	job_t                cur_q;
	logic [15:0]         fin_id_q;

	logic                scan_busy_q;
	logic [CW-1:0]       scan_idx_q;
	logic                rd_pend_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic                found_q;
	logic [IW-1:0]       best_idx_q;
	job_t                best_q;

	logic                out_valid_q;
	logic [1:0]          ev_kind_q;
	logic [15:0]         ev_job_q;
	logic [31:0]         ev_time_q;
	logic                ev_last_q;

	logic [JOB_W-1:0]    rd_word;
	job_t                rd_job;
	job_t                wr_job;
	logic                load_ok;
	logic                issue;
	logic                scan_done;
	logic                cand_better;
	logic [15:0]         emit_job;

	assign load_ok = cmd.load && (count_q < CW'(MAX_JOBS));
	assign wr_job  = '{id: job_id, arr: arrival_time, rem: burst_length};
	assign rd_job  = job_t'(rd_word);

	fss_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_table (
		.clk   (clk),
		.we    (load_ok),
		.waddr (count_q[IW-1:0]),
		.wdata (wr_job),
		.raddr (scan_idx_q[IW-1:0]),
		.rdata (rd_word)
	);

	// scan: one read issued per cycle, compared in the next cycle
	assign issue       = scan_busy_q && (scan_idx_q != count_q);
	assign scan_done   = scan_busy_q && !issue && !rd_pend_s1;
	assign cand_better = rd_pend_s1 && !done_q[rd_idx_s1] &&
		(!found_q || goes_first(policy_q, time_q, rd_job, best_q));

	always_comb begin
		case (cmd.kind)
			EV_RUN:  emit_job = cur_q.id;
			EV_FIN:  emit_job = fin_id_q;
			default: emit_job = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= 1'b0;
			count_q     <= '0;
			done_q      <= '0;
			all_fin_q   <= 1'b0;
			time_q      <= '0;
			cur_valid_q <= 1'b0;
			cur_idx_q   <= '0;
			scan_busy_q <= 1'b0;
			scan_idx_q  <= '0;
			rd_pend_s1  <= 1'b0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) policy_q <= cfg_wdata;
			if (load_ok) begin
				count_q                  <= count_q + CW'(1);
				done_q[count_q[IW-1:0]]  <= 1'b0;
			end
			if (cmd.mark_done) begin
				done_q[cur_idx_q] <= 1'b1;
				cur_valid_q       <= 1'b0;
			end
			if (cmd.load)        all_fin_q <= 1'b0;
			else if (cmd.set_all_fin) all_fin_q <= 1'b1;
			if (cmd.time_inc && (time_q != '1)) time_q <= time_q + 32'd1;
			if (cmd.take) begin
				cur_valid_q <= 1'b1;
				cur_idx_q   <= best_idx_q;
			end
			if (cmd.scan_start) begin
				scan_busy_q <= 1'b1;
				scan_idx_q  <= '0;
				found_q     <= 1'b0;
			end else begin
				if (scan_done) scan_busy_q <= 1'b0;
				if (issue)     scan_idx_q  <= scan_idx_q + CW'(1);
				if (cand_better) begin
					found_q    <= 1'b1;
					best_idx_q <= rd_idx_s1;
				end
			end
			rd_pend_s1 <= issue;
			if (cmd.emit)      out_valid_q <= 1'b1;
			else if (ev.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IW-1:0];
		if (cand_better)   best_q   <= rd_job;
		if (cmd.mark_done) fin_id_q <= cur_q.id;
		if (cmd.take)         cur_q     <= best_q;
		else if (cmd.dec_rem) cur_q.rem <= cur_q.rem - 16'd1;
		if (cmd.emit) begin
			ev_kind_q <= cmd.kind;
			ev_job_q  <= emit_job;
			ev_time_q <= time_q;
			ev_last_q <= cmd.last;
		end
	end

	assign ev.valid        = out_valid_q;
	assign ev.event_kind   = ev_kind_q;
	assign ev.event_job    = ev_job_q;
	assign ev.event_time   = ev_time_q;
	assign ev.last_of_tick = ev_last_q;

	assign stat.all_fin      = all_fin_q;
	assign stat.cur_valid    = cur_valid_q;
	assign stat.cur_arrived  = ({16'd0, cur_q.arr} <= time_q);
	assign stat.cur_rem_zero = (cur_q.rem == '0);
	assign stat.scan_done    = scan_done;
	assign stat.scan_found   = found_q;
	assign stat.out_free     = !out_valid_q || ev.ready;

endmodule

FILE: hw/rtl/fcfs_sjf_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// fcfs_sjf_tick_scheduler_core: non-preemptive FCFS / SJF tick scheduler
// Loads jobs into a table and, per tick, reports running, finished, idle or
// all-done events, picking the next job by arrival or by readiness, then shortest burst.
// ----------------------------------------------------------------------------
//
//  channel     dir  handshake          payload
//  ---------   ---  -----------------  ---------------------------------------------
//  job_in      in   valid/ready        cmd, job_id, arrival_time, burst_length
//  event_out   out  valid/ready        event_kind, event_job, event_time, last_of_tick
//  cfg         in   cfg_we             cfg_wdata (policy_mode)
//
//  A load transaction completes in its accept cycle; the next one can follow at once.
//  A tick needs one pick scan for each pick it makes (at most two); the pick
//  scan reads the job table RAM one entry per cycle through its single read port.
//  The event register frees the input side: a tick can start while an event waits.
//  Stalls on event_out hold the controller in its emit state until the slot frees.
//  arst_n clears control state; the job table is not cleared and needs no sweep.
//
module fcfs_sjf_tick_scheduler_core import fss_pkg::*; #(
	parameter int MAX_JOBS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	fss_in_if.sink      job_in,
	fss_out_if.source   event_out
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// controller: owns the handshake on job_in and the tick sequence
	fss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (job_in.valid),
		.in_cmd   (job_in.cmd),
		.in_ready (job_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: table, selection scan, time and the event register
	fss_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.job_id       (job_in.job_id),
		.arrival_time (job_in.arrival_time),
		.burst_length (job_in.burst_length),
		.cmd          (cmd),
		.stat         (stat),
		.ev           (event_out)
	);

`ifndef SYNTHESIS
	// an event is written only into a free slot
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("event written while event register still full");

	// a job is taken only at the end of a scan that found one
	a_take_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> (stat.scan_done && stat.scan_found))
		else $error("job taken without a finished successful scan");

	// once everything is done no job stays selected
	a_fin_no_cur: assert property (@(posedge clk) disable iff (!arst_n)
		stat.all_fin |-> !stat.cur_valid)
		else $error("all done flagged while a job is selected");

	// idle and done events carry no job id
	a_zero_job: assert property (@(posedge clk) disable iff (!arst_n)
		(event_out.valid && (event_out.event_kind == EV_IDLE ||
		event_out.event_kind == EV_DONE)) |-> (event_out.event_job == 16'd0))
		else $error("idle or done event with nonzero job id");
`endif

endmodule

FILE: bench/fcfs_sjf_tick_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// fcfs_sjf_tick_scheduler_core_tb: self-checking bench for the tick scheduler
// Drives load and tick transactions with bursty gaps, stalls the event
// channel on changing patterns, and checks every event against typed-in
// expectations or an in-bench scheduler that tracks the job table, the pick
// order and system time under both FCFS and SJF policy.
// ----------------------------------------------------------------------------
module fcfs_sjf_tick_scheduler_core_tb;
	import fss_pkg::*;

	localparam int   JOBS        = 16;
	localparam int   TOTAL_ITEMS = 1550;
	localparam int   SETTLE      = 64;       // covers a tick with two full pick scans
	localparam int   CYCLE_LIMIT = 1000000;
	localparam logic POLICY_SJF  = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] job;
		logic [31:0] tstamp;
		logic        last;
	} sched_event_t;

	// one row of the directed table; n_exp > 0 means the events are typed in
	typedef struct {
		bit          policy_write;
		logic        policy_val;
		logic        cmd;
		logic [15:0] id;
		logic [15:0] arr;
		logic [15:0] burst;
		int          n_exp;
		logic [1:0]  k0;
		logic [15:0] j0;
		logic [1:0]  k1;
		logic [15:0] j1;
		logic [31:0] at;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	fss_in_if  job_in ();
	fss_out_if event_out ();

	fcfs_sjf_tick_scheduler_core #(
		.MAX_JOBS(JOBS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.job_in    (job_in),
		.event_out (event_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Scheduler state as the bench sees it
	// ------------------------------------------------------------------------
	job_t         tbl [JOBS];
	bit           retired [JOBS];
	int           n_stored;
	int           cur_slot;
	bit           cur_sel;
	logic [31:0]  sys_now;
	bit           all_served;
	logic         policy;

	sched_event_t fresh [$];     // events of the transaction just accepted
	sched_event_t pending [$];   // events still owed by the block

	int errors;
	int n_events;
	int n_loads;
	int n_ticks;
	int n_phases;
	int burst_left;
	int cycles;

	// SJF readiness key: the later of arrival and now
	function automatic logic [31:0] ready_at(input int i, input logic [31:0] now);
		return ({16'd0, tbl[i].arr} > now) ? {16'd0, tbl[i].arr} : now;
	endfunction

	function automatic bit serves_first(input int a, input int b, input logic [31:0] now);
		if (policy == POLICY_SJF) begin
			if (ready_at(a, now) != ready_at(b, now))
				return ready_at(a, now) < ready_at(b, now);
			if (tbl[a].rem != tbl[b].rem)
				return tbl[a].rem < tbl[b].rem;
			return tbl[a].id < tbl[b].id;
		end
		if (tbl[a].arr != tbl[b].arr)
			return tbl[a].arr < tbl[b].arr;
		return tbl[a].id < tbl[b].id;
	endfunction

	// strict compare keeps the earlier table entry on a full tie
	function automatic bit choose_next(input logic [31:0] now, output int sel);
		bit found;
		found = 1'b0;
		sel   = 0;
		for (int i = 0; i < n_stored; i++) begin
			if (retired[i])
				continue;
			if (!found || serves_first(i, sel, now)) begin
				sel   = i;
				found = 1'b1;
			end
		end
		return found;
	endfunction

	function automatic void note(input logic [1:0] kind, input logic [15:0] job,
		input logic [31:0] t, input logic last);
		sched_event_t e;
		e = '{kind, job, t, last};
		fresh.insert(fresh.size(), e);
	endfunction

	function automatic void bump_time();
		if (sys_now != 32'hFFFF_FFFF)
			sys_now = sys_now + 1;
	endfunction

	function automatic bit has_arrived(input int i, input logic [31:0] t);
		return {16'd0, tbl[i].arr} <= t;
	endfunction

	// advance the scheduler by one accepted transaction, leaving its events in fresh
	function automatic void step_schedule(input logic cmd, input logic [15:0] id,
		input logic [15:0] arr, input logic [15:0] burst);
		logic [31:0] t;
		int          s;
		int          j;
		t = sys_now;
		fresh.delete();
		if (cmd == CMD_LOAD) begin
			// drop the load once the table is full, but still clear all-done
			if (n_stored < JOBS) begin
				tbl[n_stored]     = '{id, arr, burst};
				retired[n_stored] = 1'b0;
				n_stored++;
			end
			all_served = 1'b0;
			return;
		end
		if (all_served) begin
			note(EV_DONE, 16'd0, t, 1'b1);
			return;
		end
		if (!cur_sel) begin
			if (!choose_next(t, s)) begin
				all_served = 1'b1;
				note(EV_DONE, 16'd0, t, 1'b1);
				return;
			end
			cur_slot = s;
			cur_sel  = 1'b1;
		end
		j = cur_slot;
		if (has_arrived(j, t) && tbl[j].rem != 16'd0) begin
			note(EV_RUN, tbl[j].id, t, 1'b1);
			tbl[j].rem = tbl[j].rem - 16'd1;
			bump_time();
			return;
		end
		if (has_arrived(j, t)) begin
			// retire the job and pick its successor in the same tick
			retired[j] = 1'b1;
			cur_sel    = 1'b0;
			if (!choose_next(t, s)) begin
				note(EV_FIN, tbl[j].id, t, 1'b0);
				all_served = 1'b1;
				note(EV_DONE, 16'd0, t, 1'b1);
				return;
			end
			cur_slot = s;
			cur_sel  = 1'b1;
			if (has_arrived(s, t) && tbl[s].rem != 16'd0) begin
				note(EV_FIN, tbl[j].id, t, 1'b0);
				note(EV_RUN, tbl[s].id, t, 1'b1);
				tbl[s].rem = tbl[s].rem - 16'd1;
				bump_time();
				return;
			end
			note(EV_FIN, tbl[j].id, t, 1'b1);
			bump_time();
			return;
		end
		// selected job is still in the future: never start it early
		note(EV_IDLE, 16'd0, t, 1'b1);
		bump_time();
	endfunction

	// ------------------------------------------------------------------------
	// Command channel driver
	// ------------------------------------------------------------------------

	// send one transaction; between bursts drop valid for a random gap
	task automatic push_item(input logic cmd, input logic [15:0] id, input logic [15:0] arr,
		input logic [15:0] burst);
		if (burst_left == 0) begin
			job_in.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		job_in.valid        <= 1'b1;
		job_in.cmd          <= cmd;
		job_in.job_id       <= id;
		job_in.arrival_time <= arr;
		job_in.burst_length <= burst;
		// ready read right after the edge is the value the edge saw
		do @(posedge clk); while (!job_in.ready);
		burst_left--;
		step_schedule(cmd, id, arr, burst);
		if (cmd == CMD_LOAD)
			n_loads++;
		else
			n_ticks++;
	endtask

	// hold the channel until every owed event is out and the block has settled
	task automatic go_quiet();
		job_in.valid <= 1'b0;
		burst_left = 0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_policy(input logic p);
		go_quiet();
		cfg_we    <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		policy = p;
		n_phases++;
	endtask

	stim_row_t dir_rows [$];

	function automatic void add_row(input bit pw, input logic pv, input logic cmd,
		input logic [15:0] id, input logic [15:0] arr, input logic [15:0] burst,
		input int n, input logic [1:0] k0, input logic [15:0] j0, input logic [1:0] k1,
		input logic [15:0] j1, input logic [31:0] at);
		stim_row_t r;
		r = '{pw, pv, cmd, id, arr, burst, n, k0, j0, k1, j1, at};
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// ------------------------------------------------------------------------
	// Event channel: stall pattern and checker
	// ------------------------------------------------------------------------
	int         stall_win;
	int         stall_mode;
	logic [7:0] stall_pat;
	int         pat_idx;

	// switch between no stalls, a fixed 8-bit repeating pattern and noise, window by window
	initial begin
		event_out.ready = 1'b0;
		stall_win = 0;
		pat_idx   = 0;
		forever begin
			@(posedge clk);
			if (stall_win == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_pat  = 8'($urandom_range(1, 255));
				stall_win  = 256;
			end
			stall_win--;
			case (stall_mode)
				0: begin
					event_out.ready <= 1'b1;
				end
				1: begin
					event_out.ready <= stall_pat[pat_idx % 8];
					pat_idx++;
				end
				default: begin
					event_out.ready <= ($urandom_range(0, 3) != 0);
				end
			endcase
		end
	end

	// compare each accepted event, field by field, with the oldest one owed
	always @(posedge clk) begin
		sched_event_t want;
		if (arst_n && event_out.valid && event_out.ready) begin
			n_events++;
			if (pending.size() == 0) begin
				$error("unexpected event: kind %0d job %0d time %0d last %0d",
					event_out.event_kind, event_out.event_job, event_out.event_time,
					event_out.last_of_tick);
				errors++;
			end else begin
				want = pending.pop_front();
				if (event_out.event_kind !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, event_out.event_kind);
					errors++;
				end
				if (event_out.event_job !== want.job) begin
					$error("event_job: expected %0d, got %0d", want.job, event_out.event_job);
					errors++;
				end
				if (event_out.event_time !== want.tstamp) begin
					$error("event_time: expected %0d, got %0d", want.tstamp,
						event_out.event_time);
					errors++;
				end
				if (event_out.last_of_tick !== want.last) begin
					$error("last_of_tick: expected %0d, got %0d", want.last,
						event_out.last_of_tick);
					errors++;
				end
			end
		end
	end

	// bail out if the run hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events still owed", cycles, pending.size());
			$display("[fcfs_sjf_tick_scheduler_core] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int          n_items;
		int          len;
		int          batch;
		bit          extreme_sent;
		bit          noise;
		logic        cmd_r;
		logic [15:0] id_r;
		logic [15:0] arr_r;
		logic [15:0] burst_r;
		logic [31:0] arr_w;
		sched_event_t ev;

		// hold every input at a known value from time zero
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = 1'b0;
		job_in.valid        = 1'b0;
		job_in.cmd          = CMD_TICK;
		job_in.job_id       = 16'd0;
		job_in.arrival_time = 16'd0;
		job_in.burst_length = 16'd0;

		errors     = 0;
		n_events   = 0;
		n_loads    = 0;
		n_ticks    = 0;
		n_phases   = 0;
		burst_left = 0;
		cycles     = 0;
		n_stored   = 0;
		cur_slot   = 0;
		cur_sel    = 1'b0;
		sys_now    = 32'd0;
		all_served = 1'b0;
		policy     = POLICY_FCFS;
		n_items    = 0;
		extreme_sent = 1'b0;

		// Directed table. Under FCFS: empty table reports all done, a
		// zero-burst job with the top id finishes at once, two future jobs tie
		// on arrival so the lower id goes first and the processor idles until
		// it arrives. Under SJF: an arrived short job beats a longer one, a
		// future job loses on readiness, equal keys fall back to id and then
		// to load order.
		add_row(0, 0, CMD_TICK, 0, 0, 0, 1, EV_DONE, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 1, EV_DONE, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_LOAD, 16'hFFFF, 0, 0, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 2, EV_FIN, 16'hFFFF, EV_DONE, 0, 0);
		add_row(0, 0, CMD_LOAD, 0, 3, 2, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_LOAD, 7, 3, 1, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 1, EV_IDLE, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 1, EV_IDLE, 0, EV_RUN, 0, 1);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 1, EV_IDLE, 0, EV_RUN, 0, 2);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 1, EV_RUN, 0, EV_RUN, 0, 3);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_TICK, 0, 0, 0, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(1, POLICY_SJF, CMD_TICK, 0, 0, 0, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_LOAD, 5, 10, 4, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_LOAD, 9, 0, 3, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_LOAD, 2, 0, 3, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_LOAD, 4, 2, 1, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(0, 0, CMD_LOAD, 9, 0, 3, 0, EV_RUN, 0, EV_RUN, 0, 0);
		for (int k = 0; k < 6; k++)
			add_row(0, 0, CMD_TICK, 0, 0, 0, 0, EV_RUN, 0, EV_RUN, 0, 0);
		add_row(1, POLICY_FCFS, CMD_TICK, 0, 0, 0, 0, EV_RUN, 0, EV_RUN, 0, 0);

		// assert reset once, then release it
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (dir_rows[r].policy_write) begin
				set_policy(dir_rows[r].policy_val);
			end else begin
				push_item(dir_rows[r].cmd, dir_rows[r].id, dir_rows[r].arr, dir_rows[r].burst);
				n_items++;
				if (dir_rows[r].n_exp > 0) begin
					// typed-in events stand in for the predicted ones
					for (int k = 0; k < dir_rows[r].n_exp; k++) begin
						ev.kind   = (k == 0) ? dir_rows[r].k0 : dir_rows[r].k1;
						ev.job    = (k == 0) ? dir_rows[r].j0 : dir_rows[r].j1;
						ev.tstamp = dir_rows[r].at;
						ev.last   = (k == dir_rows[r].n_exp - 1);
						pending.insert(pending.size(), ev);
					end
				end else begin
					foreach (fresh[k])
						pending.insert(pending.size(), fresh[k]);
				end
			end
		end

		// Random phases. The table never empties, so spend the slots sparingly:
		// a few jobs at the head of a phase, the odd one mid-phase, and keep
		// the last slot for a job that never arrives and never ends.
		while (n_items < TOTAL_ITEMS) begin
			set_policy(logic'($urandom_range(0, 1)));
			len   = $urandom_range(60, 200);
			batch = $urandom_range(0, 3);
			for (int k = 0; k < len && n_items < TOTAL_ITEMS; k++) begin
				noise   = 1'b0;
				cmd_r   = CMD_TICK;
				id_r    = 16'($urandom_range(0, 65535));
				arr_r   = 16'($urandom_range(0, 65535));
				burst_r = 16'($urandom_range(0, 65535));
				if (!extreme_sent && n_items >= TOTAL_ITEMS - 250 && n_stored < JOBS) begin
					cmd_r        = CMD_LOAD;
					arr_r        = 16'hFFFF;
					burst_r      = 16'hFFFF;
					extreme_sent = 1'b1;
				end else if (n_stored < (extreme_sent ? JOBS : JOBS - 1)
					&& (k < batch || $urandom_range(0, 149) == 0)) begin
					// a small id pool now and then forces id ties
					cmd_r = CMD_LOAD;
					if ($urandom_range(0, 3) == 0)
						id_r = 16'($urandom_range(0, 3));
					if ($urandom_range(0, 2) == 0)
						arr_w = $urandom_range(0, sys_now);
					else
						arr_w = sys_now + $urandom_range(0, 40);
					arr_r   = (arr_w > 32'hFFFF) ? 16'hFFFF : arr_w[15:0];
					burst_r = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 4))
						: 16'($urandom_range(20, 200));
				end else if (n_stored == JOBS && $urandom_range(0, 19) == 0) begin
					// full table: the load is dropped, fields stay fully random
					cmd_r = CMD_LOAD;
					noise = 1'b1;
				end
				push_item(cmd_r, id_r, arr_r, burst_r);
				if (!noise)
					n_items++;
				foreach (fresh[q])
					pending.insert(pending.size(), fresh[q]);
			end
		end

		go_quiet();

		$display("ran %0d ticks and %0d loads across %0d policy settings", n_ticks, n_loads,
			n_phases);
		$display("checked %0d events; %0d jobs held, scheduler time reached %0d",
			n_events, n_stored, sys_now);
		if (errors == 0)
			$display("[fcfs_sjf_tick_scheduler_core] OK");
		else
			$display("[fcfs_sjf_tick_scheduler_core] ERROR");
		$finish;
	end

endmodule

FILE: fcfs_sjf_tick_scheduler_core.f
hw/rtl/fss_pkg.sv
hw/rtl/fss_if.sv
hw/rtl/fss_ram.sv
hw/rtl/fss_ctrl.sv
hw/rtl/fss_dp.sv
hw/rtl/fcfs_sjf_tick_scheduler_core.sv
bench/fcfs_sjf_tick_scheduler_core_tb.sv
